>>> src/uic_pkg.sv
// Package for the nonconditional instruction classifier.
// Holds the word types of both channels, the class codes and the encoding constants.
// No dependencies.
package uic_pkg;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_ADDB   = 3'd1,
    KIND_ADDH   = 3'd2,
    KIND_ADDW   = 3'd3,
    KIND_TABLE  = 3'd4,
    KIND_UNIMPL = 3'd5
  } kind_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] base_b14;
    logic [31:0] base_b15;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  dest_reg;
    logic        side;
    logic [31:0] sum_address;
  } out_word_t;

  // Encoding fields of the nonconditional space.
  localparam logic [3:0]  UNCOND_NIBBLE  = 4'b0001;
  localparam logic [4:0]  ADDB_CODE      = 5'b01111;
  localparam logic [4:0]  ADDH_CODE      = 5'b10111;
  localparam logic [4:0]  ADDW_CODE      = 5'b11111;
  localparam logic [2:0]  L_UNIT_CODE    = 3'b110;
  localparam logic [3:0]  MS_UNIT_CODE   = 4'b1100;
  localparam logic [6:0]  L_OP_ANY_DST   = 7'h36;
  localparam logic [6:0]  L_OP_LO_FIRST  = 7'h0c;
  localparam logic [6:0]  L_OP_LO_LAST   = 7'h0f;
  localparam logic [6:0]  L_OP_HI_A      = 7'h33;
  localparam logic [6:0]  L_OP_HI_B      = 7'h34;
  localparam logic [3:0]  S_OP_CODE      = 4'hb;
  localparam logic [31:0] SWE_PATTERN    = 32'h1000_0000;
  localparam logic [31:0] SWE_DONT_CARE  = 32'h0000_2001;

endpackage

>>> src/uic_decode.sv
// Classification and address arithmetic for one registered instruction word.
// Purely combinational; depends on uic_pkg.
module uic_decode (
  input  uic_pkg::in_word_t  in_word,
  output uic_pkg::out_word_t out_word
);

  logic [31:0]      w;
  logic             uncond;
  logic [6:0]       l_op;
  logic [4:0]       m_op;
  logic             l_hit;
  logic             m_hit;
  logic             s_hit;
  logic             swe_hit;
  uic_pkg::kind_t   kind;
  logic [31:0]      base;
  logic [31:0]      offset;

  assign w      = in_word.instr_word;
  assign uncond = (w[31:28] == uic_pkg::UNCOND_NIBBLE);
  assign l_op   = w[11:5];
  assign m_op   = w[10:6];

  always_comb begin
    l_hit = 1'b0;
    if (w[4:2] == uic_pkg::L_UNIT_CODE) begin
      if (l_op == uic_pkg::L_OP_ANY_DST) begin
        l_hit = 1'b1;
      end else if (((l_op >= uic_pkg::L_OP_LO_FIRST) && (l_op <= uic_pkg::L_OP_LO_LAST)) ||
                   (l_op == uic_pkg::L_OP_HI_A) || (l_op == uic_pkg::L_OP_HI_B)) begin
        // These forms only exist with a four-bit destination; bit 23 is reserved.
        l_hit = ~w[23];
      end
    end
  end

  always_comb begin
    unique case (m_op)
      5'h0a, 5'h0b, 5'h0c, 5'h0f,
      5'h14, 5'h15, 5'h16, 5'h17,
      5'h18, 5'h19, 5'h1b, 5'h1f: m_hit = (w[5:2] == uic_pkg::MS_UNIT_CODE) && !w[11];
      default:                    m_hit = 1'b0;
    endcase
  end

  assign s_hit   = (w[5:2] == uic_pkg::MS_UNIT_CODE) && (w[11:10] == 2'b11) &&
                   (w[9:6] == uic_pkg::S_OP_CODE);
  assign swe_hit = ((w & ~uic_pkg::SWE_DONT_CARE) == uic_pkg::SWE_PATTERN);

  always_comb begin
    priority if (!uncond) begin
      kind = uic_pkg::KIND_NONE;
    end else if (w[6:2] == uic_pkg::ADDB_CODE) begin
      kind = uic_pkg::KIND_ADDB;
    end else if (w[6:2] == uic_pkg::ADDH_CODE) begin
      kind = uic_pkg::KIND_ADDH;
    end else if (w[6:2] == uic_pkg::ADDW_CODE) begin
      kind = uic_pkg::KIND_ADDW;
    end else if (l_hit || m_hit || s_hit) begin
      kind = uic_pkg::KIND_TABLE;
    end else if (swe_hit) begin
      kind = uic_pkg::KIND_UNIMPL;
    end else begin
      kind = uic_pkg::KIND_NONE;
    end
  end

  assign base = w[7] ? in_word.base_b15 : in_word.base_b14;

  always_comb begin
    unique case (kind)
      uic_pkg::KIND_ADDH: offset = {16'd0, w[22:8], 1'b0};
      uic_pkg::KIND_ADDW: offset = {15'd0, w[22:8], 2'b00};
      default:            offset = {17'd0, w[22:8]};
    endcase
  end

  assign out_word.kind        = kind;
  assign out_word.dest_reg    = w[27:23];
  assign out_word.side        = w[1];
  assign out_word.sum_address = base + offset;

endmodule

>>> src/uncond_instr_classify_unit.sv
// Top level of the nonconditional instruction classifier: input register,
// decode logic and result register. Depends on uic_pkg and uic_decode.
//
//   channel | ports                            | word
//   --------+----------------------------------+-----------------------------------------
//   input   | in_valid, in_stall, in_word      | instruction word and bases B14, B15
//   result  | out_valid, out_stall, out_word   | class, destination, side, summed address
//
// One word is accepted every cycle while in_stall is low; it is held in the input register,
// decoded, and its result is then presented from the result register.
// The decode and the single 32-bit address add sit between the two registers.
// Reset clears only the two stage valid flags; the data registers are not reset.
// A stall on the result side holds the result register; the input register
// keeps filling until it too holds a word, and only then in_stall rises.
module uncond_instr_classify_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uic_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output uic_pkg::out_word_t out_word
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  uic_pkg::in_word_t  s1_word_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  uic_pkg::out_word_t out_word_r;
  uic_pkg::out_word_t dec_word;
  logic               adv_out;
  logic               adv_in;

  // The result register may load when it is empty or its word is leaving.
  assign adv_out = !out_valid_r || !out_stall;
  // The input register may load when it is empty or its word moves on.
  assign adv_in  = !s1_valid_r || adv_out;

  assign in_stall = !adv_in;

  uic_decode u_decode (
    .in_word  (s1_word_r),
    .out_word (dec_word)
  );

  always_comb begin
    s1_valid_nxt  = adv_in ? in_valid : s1_valid_r;
    out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_word_r <= in_word;
    end
    if (adv_out && s1_valid_r) begin
      out_word_r <= dec_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A word in the input register that can move on reaches the result register.
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv_out |=> out_valid_r)
    else $error("input stage word was lost on its way to the result register");

  // The input side stalls only when both stages are full and the output stalls.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled while a stage had room");

  // A word blocked in the input register stays there unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv_out |=> s1_valid_r && $stable(s1_word_r))
    else $error("blocked input stage word changed");

  // The result register never fills from an empty input stage.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r && adv_out |=> !out_valid_r)
    else $error("result register loaded without a word in the input stage");

endmodule
